FILE: hw/rtl/lcfc_pkg.sv
`default_nettype none
package lcfc_pkg;

	// Table size default
	localparam int MAX_IDS_DEF = 1024;

	// Item kinds
	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_DETECT = 2'd1;
	localparam logic [1:0] FUNC_END    = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_LINE_Y = 2'd1;
	localparam logic [1:0] REG_FPS    = 2'd2;
	localparam logic [1:0] REG_SECS   = 2'd3;

	// Widths
	localparam int FID_W  = 24;
	localparam int TID_W  = 16;
	localparam int Y_W    = 12;
	localparam int DCNT_W = 11;
	localparam int CCNT_W = 24;
	localparam int CFG_W  = 16;

	localparam logic [DCNT_W-1:0] DCNT_MAX = '1;
	localparam logic [CCNT_W-1:0] CCNT_MAX = '1;

	typedef logic [1:0] func_t;

endpackage
`default_nettype wire

FILE: hw/rtl/line_crossing_flow_counter_unit.sv
`default_nettype none
// Line-crossing flow counter.
// Input channel (in_valid/in_ready) takes one item per beat: frame start,
// detection or frame end. Output channel (out_valid/out_ready) gives one
// report beat per frame end. Config channel (cfg_valid/cfg_ready, always
// ready) writes the four registers by index.
// A detection reads the table, then writes it back; a frame start finishes
// in its accept step. A frame end passes the accept step, one multiply of
// the interval period, 24 steps of the subtract/compare unit that forms the
// frame index modulo the period, and the emit step. A frame start with
// index 0, or a frame end closing an interval, adds a sweep over all MAX_IDS
// entries clearing the interval table.
// After reset the block sweeps all MAX_IDS entries of the per-id tables
// before it accepts the first item.
// The report sits in an output register; the next item is accepted while it
// waits. A further frame end holds in its final step until the receiver
// takes the previous report.
module line_crossing_flow_counter_unit #(
	parameter int MAX_IDS = lcfc_pkg::MAX_IDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [lcfc_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire lcfc_pkg::func_t             func,
	input  wire logic [lcfc_pkg::FID_W-1:0]  frame_no,
	input  wire logic [lcfc_pkg::TID_W-1:0]  obj_id,
	input  wire logic [lcfc_pkg::Y_W-1:0]    box_top,
	input  wire logic [lcfc_pkg::Y_W-1:0]    box_bottom,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [lcfc_pkg::FID_W-1:0]       out_frame_no,
	output logic [lcfc_pkg::DCNT_W-1:0]      total_count,
	output logic [lcfc_pkg::CCNT_W-1:0]      in_count,
	output logic [lcfc_pkg::CCNT_W-1:0]      out_count,
	output logic                             interval_valid,
	output logic [lcfc_pkg::DCNT_W-1:0]      interval_count,
	output logic                             id_overflow
);
	import lcfc_pkg::*;

	localparam int AW = $clog2(MAX_IDS);
	localparam int FW = 2 + Y_W;
	localparam logic [AW-1:0] LAST_ID = AW'(MAX_IDS - 1);

	localparam logic [2:0] ST_RCLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DET  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_REM  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_ICLR = 3'd6;

	logic [2:0]        state_q;
	logic [AW-1:0]     cnt_q;
	logic [4:0]        bit_q;
	logic [FID_W-1:0]  fid_q;
	logic [FID_W-1:0]  per_q;
	logic [FID_W-1:0]  rem_q;
	logic [AW-1:0]     id_q;
	logic [Y_W-1:0]    cy_q;

	logic              en_q;
	logic [Y_W-1:0]    ey_q;
	logic [7:0]        fps_q;
	logic [15:0]       secs_q;

	logic [DCNT_W-1:0] dtot_q;
	logic [DCNT_W-1:0] dint_q;
	logic [CCNT_W-1:0] cin_q;
	logic [CCNT_W-1:0] cout_q;
	logic              ovf_q;

	logic              in_acc;
	logic              load;
	logic              id_ok;
	logic [Y_W:0]      ysum;
	logic [FW-1:0]     fl_rdata;
	logic [0:0]        iv_rdata;
	logic              fl_we;
	logic [AW-1:0]     fl_waddr;
	logic [FW-1:0]     fl_wdata;
	logic              iv_we;
	logic [AW-1:0]     iv_waddr;
	logic [0:0]        iv_wdata;
	logic [Y_W-1:0]    py;
	logic              cvalid;
	logic              seen;
	logic              cross_in;
	logic              cross_out;
	logic [7:0]        fps_eff;
	logic [15:0]       secs_eff;
	logic [FID_W:0]    trial;
	logic [FID_W-1:0]  rem_nxt;
	logic              closes;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign id_ok     = ({1'b0, obj_id} < 17'(MAX_IDS));
	assign ysum      = {1'b0, box_top} + {1'b0, box_bottom};

	// Per-id tables: {seen_ever, center_valid, prev_center_y} and seen_interval
	lcfc_ram #(.WIDTH(FW), .DEPTH(MAX_IDS)) u_flags (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(obj_id[AW-1:0]), .rdata(fl_rdata)
	);
	lcfc_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_ivl (
		.clk(clk), .we(iv_we), .waddr(iv_waddr), .wdata(iv_wdata),
		.raddr(obj_id[AW-1:0]), .rdata(iv_rdata)
	);

	// Detection update decode
	assign seen      = fl_rdata[FW-1];
	assign cvalid    = fl_rdata[FW-2];
	assign py        = fl_rdata[Y_W-1:0];
	assign cross_in  = en_q && cvalid && (py <= ey_q) && (cy_q > ey_q);
	assign cross_out = en_q && cvalid && (py >= ey_q) && (cy_q < ey_q);

	always_comb begin
		fl_we    = 1'b0;
		fl_waddr = id_q;
		fl_wdata = {1'b1, en_q ? 1'b1 : cvalid, en_q ? cy_q : py};
		iv_we    = 1'b0;
		iv_waddr = id_q;
		iv_wdata = 1'b1;
		case (state_q)
			ST_RCLR: begin
				fl_we    = 1'b1;
				fl_waddr = cnt_q;
				fl_wdata = '0;
				iv_we    = 1'b1;
				iv_waddr = cnt_q;
				iv_wdata = 1'b0;
			end
			ST_ICLR: begin
				iv_we    = 1'b1;
				iv_waddr = cnt_q;
				iv_wdata = 1'b0;
			end
			ST_DET: begin
				fl_we = 1'b1;
				iv_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Restoring remainder step
	assign fps_eff  = (fps_q == '0) ? 8'd1 : fps_q;
	assign secs_eff = (secs_q == '0) ? 16'd1 : secs_q;
	assign trial    = {rem_q, fid_q[bit_q]};
	assign rem_nxt  = (trial >= {1'b0, per_q}) ? FID_W'(trial - {1'b0, per_q})
	                                           : trial[FID_W-1:0];
	assign closes   = (rem_q == '0);
	assign load     = (state_q == ST_EMIT) && (!out_valid || out_ready);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			ey_q   <= '0;
			fps_q  <= 8'd30;
			secs_q <= 16'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE: en_q   <= cfg_data[0];
				REG_LINE_Y: ey_q   <= cfg_data[Y_W-1:0];
				REG_FPS:    fps_q  <= cfg_data[7:0];
				REG_SECS:   secs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fid_q <= frame_no;
			id_q  <= obj_id[AW-1:0];
			cy_q  <= ysum[Y_W:1];
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RCLR;
			cnt_q   <= '0;
			bit_q   <= '0;
			per_q   <= '0;
			rem_q   <= '0;
			dtot_q  <= '0;
			dint_q  <= '0;
			cin_q   <= '0;
			cout_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_RCLR, ST_ICLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ID) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							FUNC_START: begin
								ovf_q <= 1'b0;
								if (frame_no == '0) begin
									dint_q  <= '0;
									state_q <= ST_ICLR;
								end
							end
							FUNC_DETECT: begin
								if (id_ok) state_q <= ST_DET;
								else ovf_q <= 1'b1;
							end
							FUNC_END: state_q <= ST_MUL;
							default: ;
						endcase
					end
				end
				ST_DET: begin
					if (cross_in && cin_q != CCNT_MAX) cin_q <= cin_q + 1'b1;
					if (cross_out && cout_q != CCNT_MAX) cout_q <= cout_q + 1'b1;
					if (!seen && dtot_q != DCNT_MAX) dtot_q <= dtot_q + 1'b1;
					if (!iv_rdata[0] && dint_q != DCNT_MAX) dint_q <= dint_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					per_q   <= FID_W'(fps_eff) * FID_W'(secs_eff);
					rem_q   <= '0;
					bit_q   <= 5'(FID_W - 1);
					state_q <= ST_REM;
				end
				ST_REM: begin
					rem_q <= rem_nxt;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						ovf_q <= 1'b0;
						if (closes) begin
							dint_q  <= '0;
							state_q <= ST_ICLR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_frame_no   <= fid_q;
			total_count    <= dtot_q;
			in_count       <= cin_q;
			out_count      <= cout_q;
			interval_valid <= closes;
			interval_count <= closes ? dint_q : '0;
			id_overflow    <= ovf_q;
		end
	end

	// Checks
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("report raised outside emit step");
	a_ivl_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		dint_q <= dtot_q)
		else $error("interval count above total count");
	a_ovf_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !ovf_q)
		else $error("overflow flag not cleared after report");

endmodule
`default_nettype wire

FILE: hw/rtl/lcfc_ram.sv
`default_nettype none
module lcfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
